// ===== rtl/pbd_pkg.sv =====
// Shared types, widths and constants for the pulse beat detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package pbd_pkg;

  // Field widths
  localparam int SAMPLE_W     = 18;
  localparam int TIME_W       = 32;
  localparam int INTERVAL_W   = 16;
  localparam int WINDOW_W     = 16;
  localparam int MULT_W       = 6;
  localparam int WIN_BEATS_W  = 6;
  localparam int BPM_W        = 8;

  // Port widths
  localparam int IN_TDATA_W  = 56;  // 50 bits of fields, padded to whole bytes
  localparam int OUT_TDATA_W = 24;  // 18 bits of fields, padded to whole bytes
  localparam int OUT_TUSER_W = 1;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  // Default geometry
  localparam int AVERAGE_DEPTH_DEF = 20;
  localparam int HISTORY_DEPTH_DEF = 4;
  localparam int QUEUE_DEPTH       = 2;

  // Register reset values
  localparam logic [SAMPLE_W-1:0]   FINGER_THRESHOLD_RST = SAMPLE_W'(9000);
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST     = INTERVAL_W'(300);
  localparam logic [WINDOW_W-1:0]   WINDOW_RST           = WINDOW_W'(15000);
  localparam logic [MULT_W-1:0]     MULT_RST             = MULT_W'(4);

  localparam logic [BPM_W-1:0]       BPM_HISTORY_RST = BPM_W'(60);
  localparam logic [BPM_W-1:0]       BPM_MAX         = '1;
  localparam logic [WIN_BEATS_W-1:0] WIN_BEATS_MAX   = '1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FINGER_THRESHOLD = 4'd0,
    CFG_MIN_INTERVAL     = 4'd1,
    CFG_WINDOW           = 4'd2,
    CFG_BPM_MULT         = 4'd3
  } pbd_cfg_index_t;

  // One request as it travels from the front end to the back end
  typedef struct packed {
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] level;   // moving average including this sample
  } pbd_item_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } pbd_q_status_t;

endpackage

`default_nettype wire

// ===== rtl/pulse_beat_detector_bpm.sv =====
// Top level of the pulse beat detector with BPM estimate.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
//
// Usage:
//   s_axis carries one request per infrared sample: ir_sample and a wrapping
//   millisecond timestamp. m_axis returns exactly one result per request, in
//   order: beat, finger_off, window_bpm and bpm_average in tdata, with
//   report_valid in tuser marking a closed counting window.
//   The cfg channel writes the four registers (finger threshold, refractory
//   interval, window length, BPM multiplier); cfg_ready is always high and
//   writes are meant for when no request is in flight.
// Timing:
//   One request per cycle sustained while m_axis does not stall. The front
//   stage registers the request with its moving average, the queue then
//   takes it when not full, and the back stage updates the detector and
//   loads the result register as it pops the entry. The moving-average ring
//   is a memory read one slot ahead, and the single back-stage state update
//   per cycle sets the rate.
// Reset and stalls:
//   rst clears the ring (by valid bits, no clearing pass), detector state and
//   history (all sixty). When m_axis stalls the result register holds, the
//   queue fills, then s_axis_tready drops; nothing is lost or repeated.
`default_nettype none

module pulse_beat_detector_bpm
  import pbd_pkg::*;
#(
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Input requests
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // ir_sample[17:0], time_ms[49:18]
  // Results
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // beat[0], finger_off[1],
                                                      // window_bpm[9:2], bpm_average[17:10]
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,   // report_valid[0]
  // Register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  pbd_q_status_t    q_status;
  pbd_item_t        push_item;
  pbd_item_t        pop_item;
  logic             push;
  logic             pop;
  logic             out_beat;
  logic             out_finger_off;
  logic             out_report;
  logic [BPM_W-1:0] out_window_bpm;
  logic [BPM_W-1:0] out_bpm_average;

  // Front: moving average
  pbd_front #(
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[SAMPLE_W-1:0]),
    .in_time   (s_axis_tdata[SAMPLE_W +: TIME_W]),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  pbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Back: detection, windowing, history, result register
  pbd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_status        (q_status),
    .q_item          (pop_item),
    .pop             (pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_beat        (out_beat),
    .out_finger_off  (out_finger_off),
    .out_report      (out_report),
    .out_window_bpm  (out_window_bpm),
    .out_bpm_average (out_bpm_average)
  );

  // Pack result fields, lowest bit first, zero padded
  assign m_axis_tdata = {(OUT_TDATA_W - 2 - 2 * BPM_W)'(0), out_bpm_average,
                         out_window_bpm, out_finger_off, out_beat};
  assign m_axis_tuser = out_report;

endmodule

`default_nettype wire

// ===== rtl/pbd_front.sv =====
// Front end: takes requests, runs the moving average over a ring memory.
// Depends on pbd_pkg; feeds pbd_queue.
`default_nettype none

module pbd_front
  import pbd_pkg::*;
#(
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [TIME_W-1:0]   in_time,
  input  wire pbd_q_status_t       q_status,
  output logic                     push,
  output pbd_item_t                push_item
);

  localparam int POS_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(AVERAGE_DEPTH);
  // floor(x / D) == (x * ceil(2^S / D)) >> S for all x < 2^SUM_W
  localparam int DIV_S  = SUM_W + $clog2(AVERAGE_DEPTH);
  localparam int PROD_W = SUM_W + DIV_S + 1;
  localparam logic [DIV_S:0] RECIP = (DIV_S + 1)'(((64'd1 << DIV_S)
      + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));

  logic [SAMPLE_W-1:0]      ring [AVERAGE_DEPTH];
  logic [AVERAGE_DEPTH-1:0] ring_valid;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_next;
  logic [POS_W-1:0]         rd_addr;
  logic [SAMPLE_W-1:0]      rd_data;
  logic                     rd_valid;
  logic [SAMPLE_W-1:0]      old_sample;
  logic [SUM_W-1:0]         running_sum;
  logic                     accept;
  logic                     f_valid;
  logic [SAMPLE_W-1:0]      f_sample;
  logic [TIME_W-1:0]        f_time;
  logic [PROD_W-1:0]        avg_prod;

  assign in_ready = !f_valid || !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = f_valid && !q_status.full;

  assign pos_next   = (pos == POS_W'(AVERAGE_DEPTH - 1)) ? '0 : pos + 1'b1;
  // Read ahead: the slot the next sample will overwrite
  assign rd_addr    = accept ? pos_next : pos;
  assign old_sample = rd_valid ? rd_data : '0;

  // Ring memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[pos] <= in_sample;
    end
    if (accept && (rd_addr == pos)) begin
      rd_data <= in_sample;
    end else begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid  <= '0;
      rd_valid    <= 1'b0;
      pos         <= '0;
      running_sum <= '0;
      f_valid     <= 1'b0;
    end else begin
      rd_valid <= (accept && (rd_addr == pos)) || ring_valid[rd_addr];
      if (accept) begin
        ring_valid[pos] <= 1'b1;
        pos             <= pos_next;
        running_sum     <= running_sum - SUM_W'(old_sample) + SUM_W'(in_sample);
        f_valid         <= 1'b1;
      end else if (push) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_sample <= in_sample;
      f_time   <= in_time;
    end
  end

  // running_sum already holds the staged sample
  assign avg_prod = PROD_W'(running_sum) * PROD_W'(RECIP);

  always_comb begin
    push_item.time_ms = f_time;
    push_item.sample  = f_sample;
    push_item.level   = avg_prod[DIV_S +: SAMPLE_W];
  end

endmodule

`default_nettype wire

// ===== rtl/pbd_queue.sv =====
// Short queue between the front end and the back end.
// Depends on pbd_pkg.
`default_nettype none

module pbd_queue
  import pbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire pbd_item_t push_item,
  input  wire logic      pop,
  output pbd_item_t      pop_item,
  output pbd_q_status_t  status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pbd_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_drops: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on read");
`endif

endmodule

`default_nettype wire

// ===== rtl/pbd_back.sv =====
// Back end: finger test, window, peak detection, BPM history, result register.
// Depends on pbd_pkg; fed by pbd_queue.
`default_nettype none

module pbd_back
  import pbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire pbd_q_status_t          q_status,
  input  wire pbd_item_t              q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_beat,
  output logic                        out_finger_off,
  output logic                        out_report,
  output logic [BPM_W-1:0]            out_window_bpm,
  output logic [BPM_W-1:0]            out_bpm_average
);

  localparam int HPOS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HSUM_W  = BPM_W + $clog2(HISTORY_DEPTH);
  localparam int MEAN_S  = HSUM_W + $clog2(HISTORY_DEPTH);
  localparam int MPROD_W = HSUM_W + MEAN_S + 1;
  localparam logic [MEAN_S:0] MEAN_RECIP = (MEAN_S + 1)'(((64'd1 << MEAN_S)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
  localparam int PROD_W  = WIN_BEATS_W + MULT_W;

  // Configuration
  logic [SAMPLE_W-1:0]   finger_threshold;
  logic [INTERVAL_W-1:0] min_interval;
  logic [WINDOW_W-1:0]   window_ms;
  logic [MULT_W-1:0]     bpm_mult;

  // Detector state
  logic [SAMPLE_W-1:0]    previous_average;
  logic                   rising_flag;
  logic [TIME_W-1:0]      prev_beat_ms;
  logic [TIME_W-1:0]      window_start;
  logic [WIN_BEATS_W-1:0] win_beats;
  logic [BPM_W-1:0]       history [HISTORY_DEPTH];
  logic [HPOS_W-1:0]      hpos;
  logic [HSUM_W-1:0]      hist_sum;

  // Per-request logic
  logic                   off;
  logic [TIME_W-1:0]      ws_eff;
  logic [WIN_BEATS_W-1:0] bc_eff;
  logic [TIME_W-1:0]      elapsed;
  logic                   close;
  logic [PROD_W-1:0]      product;
  logic [BPM_W-1:0]       wbpm;
  logic [HSUM_W-1:0]      hist_sum_next;
  logic [TIME_W-1:0]      since_beat;
  logic                   going_up;
  logic                   hit;
  logic [WIN_BEATS_W-1:0] bc_after;
  logic [WIN_BEATS_W-1:0] win_beats_next;

  // Result register
  logic               o_beat;
  logic               o_off;
  logic               o_report;
  logic [BPM_W-1:0]   o_wbpm;
  logic [HSUM_W-1:0]  o_hsum;
  logic [MPROD_W-1:0] mean_prod;

  assign cfg_ready = 1'b1;
  assign pop       = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_threshold <= FINGER_THRESHOLD_RST;
      min_interval     <= MIN_INTERVAL_RST;
      window_ms        <= WINDOW_RST;
      bpm_mult         <= MULT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FINGER_THRESHOLD: finger_threshold <= cfg_data;
        CFG_MIN_INTERVAL:     min_interval     <= cfg_data[INTERVAL_W-1:0];
        CFG_WINDOW:           window_ms        <= cfg_data[WINDOW_W-1:0];
        CFG_BPM_MULT:         bpm_mult         <= cfg_data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  // Finger test restarts the window before the window test
  assign off     = q_item.sample < finger_threshold;
  assign ws_eff  = off ? q_item.time_ms : window_start;
  assign bc_eff  = off ? '0 : win_beats;
  assign elapsed = q_item.time_ms - ws_eff;
  assign close   = elapsed >= TIME_W'(window_ms);

  assign product = PROD_W'(bc_eff) * PROD_W'(bpm_mult);
  assign wbpm    = (product > PROD_W'(BPM_MAX)) ? BPM_MAX : product[BPM_W-1:0];
  assign hist_sum_next = hist_sum - HSUM_W'(history[hpos]) + HSUM_W'(wbpm);

  // Rise then fall, gated by the refractory time
  assign since_beat = q_item.time_ms - prev_beat_ms;
  assign going_up   = q_item.level > previous_average;
  assign hit        = !going_up && rising_flag && (q_item.level < previous_average)
                      && (since_beat > TIME_W'(min_interval));

  assign bc_after       = close ? '0 : bc_eff;
  assign win_beats_next = (hit && (bc_after != WIN_BEATS_MAX)) ? bc_after + 1'b1
                                                               : bc_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_average <= '0;
      rising_flag      <= 1'b0;
      prev_beat_ms     <= '0;
      window_start     <= '0;
      win_beats        <= '0;
      hpos             <= '0;
      hist_sum         <= HSUM_W'(BPM_HISTORY_RST * HISTORY_DEPTH);
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= BPM_HISTORY_RST;
      end
    end else if (pop) begin
      previous_average <= q_item.level;
      if (going_up) begin
        rising_flag <= 1'b1;
      end else if (q_item.level < previous_average) begin
        rising_flag <= 1'b0;
      end
      if (hit) begin
        prev_beat_ms <= q_item.time_ms;
      end
      win_beats    <= win_beats_next;
      window_start <= close ? q_item.time_ms : ws_eff;
      if (close) begin
        history[hpos] <= wbpm;
        hpos          <= (hpos == HPOS_W'(HISTORY_DEPTH - 1)) ? '0 : hpos + 1'b1;
        hist_sum      <= hist_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      o_beat   <= hit;
      o_off    <= off;
      o_report <= close;
      o_wbpm   <= close ? wbpm : '0;
      o_hsum   <= hist_sum_next;
    end
  end

  // Mean of the history by reciprocal multiply on the registered sum
  assign mean_prod = MPROD_W'(o_hsum) * MPROD_W'(MEAN_RECIP);

  assign out_beat        = o_beat;
  assign out_finger_off  = o_off;
  assign out_report      = o_report;
  assign out_window_bpm  = o_wbpm;
  assign out_bpm_average = o_report ? mean_prod[MEAN_S +: BPM_W] : '0;

`ifndef SYNTHESIS
  a_beat_marks_time: assert property (@(posedge clk) disable iff (rst)
    (pop && hit) |=> (!rising_flag && prev_beat_ms == $past(q_item.time_ms)))
    else $error("beat did not end the rise or record its time");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && close) |=> (win_beats <= WIN_BEATS_W'(1)
                        && window_start == $past(q_item.time_ms)))
    else $error("closed window not restarted");

  a_finger_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && off && !hit) |=> (win_beats == '0))
    else $error("finger off left a beat count");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_report) |-> (out_window_bpm == '0 && out_bpm_average == '0))
    else $error("report fields set without a report");
`endif

endmodule

`default_nettype wire

// ===== verif/pulse_beat_checker.sv =====
// Checker for the pulse beat detector: watches the request, result and
// register channels, predicts each result and compares it field by field.
// Depends on pbd_pkg for widths, reset values and register indexes.
module pulse_beat_checker
  import pbd_pkg::*;
#(
  parameter int AVERAGE_DEPTH = AVERAGE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     outstanding
);

  typedef struct packed {
    logic             beat;
    logic             finger_off;
    logic             report;
    logic [BPM_W-1:0] window_bpm;
    logic [BPM_W-1:0] bpm_average;
  } pulse_result_t;

  // registers as the block should hold them
  logic [SAMPLE_W-1:0]   threshold;
  logic [INTERVAL_W-1:0] min_gap;
  logic [WINDOW_W-1:0]   window_len;
  logic [MULT_W-1:0]     multiplier;

  // detector state
  logic [SAMPLE_W-1:0]    ring [AVERAGE_DEPTH];
  int                     ring_pos;
  logic [22:0]            ring_sum;
  logic [SAMPLE_W-1:0]    prev_level;
  logic                   rising;
  logic [TIME_W-1:0]      last_beat;
  logic [TIME_W-1:0]      window_start;
  logic [WIN_BEATS_W-1:0] win_beats;
  logic [BPM_W-1:0]       history [HISTORY_DEPTH];
  int                     history_pos;

  pulse_result_t pending_results[$];
  pulse_result_t got, want;
  int            errors = 0;
  int            result_index = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    if (errors < 50)
      $display("MISMATCH result %0d %s: expected %0d got %0d", result_index, what, exp_v,
               got_v);
    errors++;
  endtask

  task automatic clear_detector();
    threshold    = FINGER_THRESHOLD_RST;
    min_gap      = MIN_INTERVAL_RST;
    window_len   = WINDOW_RST;
    multiplier   = MULT_RST;
    foreach (ring[i]) ring[i] = '0;
    ring_pos     = 0;
    ring_sum     = '0;
    prev_level   = '0;
    rising       = 1'b0;
    last_beat    = '0;
    window_start = '0;
    win_beats    = '0;
    foreach (history[i]) history[i] = BPM_HISTORY_RST;
    history_pos  = 0;
  endtask

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (pbd_cfg_index_t'(idx))
      CFG_FINGER_THRESHOLD: threshold = value[SAMPLE_W-1:0];
      CFG_MIN_INTERVAL:     min_gap = value[INTERVAL_W-1:0];
      CFG_WINDOW:           window_len = value[WINDOW_W-1:0];
      CFG_BPM_MULT:         multiplier = value[MULT_W-1:0];
      default: ;  // unmapped index: no effect
    endcase
  endtask

  // Finger test, then window close, then moving average and peak search.
  task automatic predict_beat(input logic [SAMPLE_W-1:0] ir, input logic [TIME_W-1:0] now,
                              output pulse_result_t r);
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   since_beat;
    logic [SAMPLE_W-1:0] level;
    int                  product;
    int                  total;
    logic                hit;
    r = '0;
    r.finger_off = (ir < threshold);
    if (r.finger_off) begin
      window_start = now;
      win_beats    = '0;
    end
    elapsed = now - window_start;
    if (elapsed >= TIME_W'(window_len)) begin
      product = int'(win_beats) * int'(multiplier);
      r.window_bpm = (product > int'(BPM_MAX)) ? BPM_MAX : BPM_W'(product);
      history[history_pos] = r.window_bpm;
      history_pos = (history_pos + 1) % HISTORY_DEPTH;
      total = 0;
      foreach (history[i]) total += int'(history[i]);
      r.bpm_average = BPM_W'(total / HISTORY_DEPTH);
      r.report      = 1'b1;
      win_beats     = '0;
      window_start  = now;
    end
    // running sum never goes negative, so 23-bit wrap is harmless
    ring_sum = ring_sum - 23'(ring[ring_pos]) + 23'(ir);
    ring[ring_pos] = ir;
    ring_pos = (ring_pos + 1) % AVERAGE_DEPTH;
    level = SAMPLE_W'(ring_sum / AVERAGE_DEPTH);
    hit = 1'b0;
    if (level > prev_level) begin
      rising = 1'b1;
    end else if (rising && level < prev_level) begin
      since_beat = now - last_beat;
      if (since_beat > TIME_W'(min_gap)) begin
        hit       = 1'b1;
        last_beat = now;
      end
      rising = 1'b0;
    end
    prev_level = level;
    if (hit && win_beats != WIN_BEATS_MAX) win_beats++;
    r.beat = hit;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_detector();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (m_axis_tvalid && m_axis_tready) begin
        got.beat        = m_axis_tdata[0];
        got.finger_off  = m_axis_tdata[1];
        got.window_bpm  = m_axis_tdata[9:2];
        got.bpm_average = m_axis_tdata[17:10];
        got.report      = m_axis_tuser[0];
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", 0, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.beat !== want.beat) report_mismatch("beat", want.beat, got.beat);
          if (got.finger_off !== want.finger_off)
            report_mismatch("finger_off", want.finger_off, got.finger_off);
          if (got.report !== want.report)
            report_mismatch("report_valid", want.report, got.report);
          if (got.window_bpm !== want.window_bpm)
            report_mismatch("window_bpm", want.window_bpm, got.window_bpm);
          if (got.bpm_average !== want.bpm_average)
            report_mismatch("bpm_average", want.bpm_average, got.bpm_average);
        end
        result_index++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[SAMPLE_W +: TIME_W], want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= errors;
  end

endmodule

// ===== verif/pulse_beat_detector_bpm_tb.sv =====
// Testbench top for pulse_beat_detector_bpm: clock, reset, requests,
// register writes and random flow control; checking sits in pulse_beat_checker.
// Depends on pbd_pkg, the block's RTL and verif/pulse_beat_checker.sv.
module pulse_beat_detector_bpm_tb;
  import pbd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'hF;  // not mapped to any register
  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES = 400;   // long result back-pressure stretch
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;

  // flow control knobs, percent of cycles spent idle / stalled
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  logic [TIME_W-1:0] now_ms = '0;  // running timestamp for well-formed trains
  int threshold_now = 9000;        // finger threshold currently in force

  always #10 clk = ~clk;

  pulse_beat_detector_bpm dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pulse_beat_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // Result side. A hold request starts a long stall counted here; otherwise
  // tready follows the current stall percentage.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request  <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted request, result or register write keeps it quiet.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One request; returns at the edge where it was taken, tvalid still high.
  task automatic push_sample(input logic [SAMPLE_W-1:0] ir, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - SAMPLE_W - TIME_W){1'b0}}, t, ir};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic end_run();
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait for every expected result, then allow some pipeline slack.
  task automatic settle();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full 18-bit values go out on purpose: the narrow registers must mask.
  task automatic configure(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] gap,
                           input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] mult);
    put_register(CFG_FINGER_THRESHOLD, thr);
    put_register(CFG_MIN_INTERVAL, gap);
    put_register(CFG_WINDOW, win);
    put_register(CFG_BPM_MULT, mult);
    cfg_valid <= 1'b0;
    threshold_now = int'(thr);
  endtask

  // Square-wave pulse train above the finger threshold; the 20-tap average
  // turns it into ramps and plateaus. Mixed in: finger-off dips and noise.
  task automatic send_train(input int count);
    int hi_len, lo_len, phase, base, amp, level, roll;
    logic [SAMPLE_W-1:0] ir;
    logic [TIME_W-1:0] t;
    hi_len = $urandom_range(2, 30);
    lo_len = $urandom_range(2, 30);
    base   = threshold_now + $urandom_range(0, 20000);
    amp    = $urandom_range(500, 100000);
    phase  = $urandom_range(0, hi_len + lo_len - 1);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      now_ms += $urandom_range(2, 40);
      t = now_ms;
      if (roll < 5) begin
        ir = SAMPLE_W'($urandom);
        if ($urandom_range(1)) t = $urandom;
      end else if (roll < 8) begin
        ir = (threshold_now == 0) ? '0 : SAMPLE_W'($urandom_range(threshold_now - 1, 0));
      end else begin
        level = base + ((phase < hi_len) ? amp : 0) + $urandom_range(0, 2);
        if (level > SAMPLE_MAX) level = SAMPLE_MAX;
        ir = SAMPLE_W'(level);
      end
      phase = (phase + 1) % (hi_len + lo_len);
      push_sample(ir, t);
    end
  endtask

  // High-low-low pattern at 1 ms steps: one peak every three requests once
  // the average ring is full, enough to saturate the beat count.
  task automatic send_burst(input int count);
    logic [SAMPLE_W-1:0] hi, lo;
    hi = SAMPLE_W'($urandom_range(100000, SAMPLE_MAX));
    lo = SAMPLE_W'($urandom_range(0, 50000));
    now_ms += 70000;  // opens a fresh window on the first request
    for (int i = 0; i < count; i++) begin
      push_sample((i % 3 == 0) ? hi : lo, now_ms);
      now_ms += 1;
    end
    now_ms += 70000;  // closes the saturated window
    push_sample(hi, now_ms);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset register values.
    push_sample('0, '0);                             // finger off at time zero
    push_sample(SAMPLE_W'(SAMPLE_MAX), '1);          // window closes at the last timestamp before the wrap
    push_sample(SAMPLE_W'(8999), '1);                // one below threshold
    push_sample(SAMPLE_W'(9000), TIME_W'(14998));    // at threshold, window still open
    push_sample(SAMPLE_W'(9000), TIME_W'(14999));    // elapsed equals window length
    now_ms = TIME_W'(15000);
    for (int i = 0; i < 10; i++) begin
      now_ms += 50;
      push_sample(SAMPLE_W'(200000), now_ms);
    end
    for (int i = 0; i < 8; i++) begin                // ring wraps: average falls, beat
      now_ms += 50;
      push_sample(SAMPLE_W'(20000), now_ms);
    end
    end_run();
    settle();

    // Long receiver hold-off while requests keep coming: queue fills, input stalls.
    configure(18'd1000, 18'd100, 18'd800, 18'd4);
    hold_request <= 1'b1;
    repeat (2) send_train(50);
    end_run();
    settle();

    // Saturation: count and BPM clip, window value masked to 16 bits.
    send_idle_pct = 73;
    configure(18'd0, 18'd0, 18'h3FFFF, 18'd63);
    put_register(CFG_SPARE, 18'h3FFFF);
    cfg_valid <= 1'b0;
    send_burst(240);
    end_run();
    settle();

    // Zero window, zero multiplier, maximum threshold and refractory time.
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    configure(18'h3FFFF, 18'h3FFFF, 18'd0, 18'd0);
    repeat (2) send_train(30);
    end_run();
    settle();

    // Random registers, timestamps running up toward the 32-bit wrap.
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    now_ms = 32'hFFFF_F000;
    configure(CFG_DATA_W'($urandom_range(0, 20000)), CFG_DATA_W'($urandom_range(0, 600)),
              CFG_DATA_W'($urandom_range(1, 3000)), CFG_DATA_W'($urandom_range(1, 60)));
    repeat (2) send_train(30);
    end_run();
    settle();

    // Shortest non-zero window with a multiplier of 60.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(18'd5000, 18'd300, 18'd1, 18'd60);
    repeat (2) send_train(30);
    end_run();
    settle();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
